// ===== hdl/rmsac_pkg.sv =====
// Shared types, codes and the bound function for the rate-monotonic admission block.
// Used by every module under hdl/; depends on nothing.

package rmsac_pkg;

  localparam int UTIL_W      = 32;
  localparam int TASK_W      = 7;
  localparam int TASK_LIMIT  = 64;
  localparam int TASK_IDX_W  = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_ADMIT   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [2:0] ST_ADMITTED = 3'd0;
  localparam logic [2:0] ST_EXCEEDED = 3'd1;
  localparam logic [2:0] ST_BAD_PARM = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic        func;
    logic [7:0]  cpu;
    logic [63:0] budget;
    logic [63:0] period;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [UTIL_W-1:0] utilization;
    logic [TASK_W-1:0] task_count;
  } out_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic        func;
    logic [7:0]  cpu;
    logic [63:0] budget;
    logic [63:0] period;
    logic        cpu_bad;
    logic        bad;
    logic        sat;
  } job_t;

  // 1/v by Newton iteration, for 0 < v < 256; elaboration only
  function automatic real recip(real v);
    real r;
    int  i;
    r = 0.0078125;
    for (i = 0; i < 40; i++) begin
      r = r * (2.0 - v * r);
    end
    return r;
  endfunction

  // floor(n * (2^(1/n) - 1) * 2^fb), evaluated at elaboration only.
  // Series form ln2 * sum x^(k-1)/k!, x = ln2/n, avoids cancellation.
  function automatic logic [UTIL_W-1:0] ll_bound(int n, int fb);
    real x;
    real term;
    real acc;
    real scale;
    int  k;
    x     = 0.6931471805599453 * recip(real'(n));
    term  = 1.0;
    acc   = 1.0;
    scale = 1.0;
    for (k = 2; k <= 24; k++) begin
      term = term * x * recip(real'(k));
      acc  = acc + term;
    end
    for (k = 0; k < fb; k++) begin
      scale = scale * 2.0;
    end
    if (n == 1) begin
      return UTIL_W'(64'd1 << fb);
    end
    return UTIL_W'($rtoi(0.6931471805599453 * acc * scale));
  endfunction

endpackage

// ===== hdl/rmsac_front.sv =====
// Front stage: takes request transfers, flags bad parameters and quotient saturation.
// Depends on rmsac_pkg; feeds rmsac_queue.

module rmsac_front #(
  parameter int NUM_CPUS  = 24,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmsac_pkg::in_t     in_data,
  output logic               push,
  output rmsac_pkg::job_t    push_data,
  input  logic               q_full
);

  logic            hold_valid_r;
  rmsac_pkg::job_t hold_r;
  rmsac_pkg::job_t job_nxt;
  logic            take;

  assign in_stall  = hold_valid_r && q_full;
  assign take      = in_valid && !in_stall;
  assign push      = hold_valid_r;
  assign push_data = hold_r;

  always_comb begin
    job_nxt         = '0;
    job_nxt.func    = in_data.func;
    job_nxt.cpu     = in_data.cpu;
    job_nxt.budget  = in_data.budget;
    job_nxt.period  = in_data.period;
    job_nxt.cpu_bad = {1'b0, in_data.cpu} >= 9'(NUM_CPUS);
    job_nxt.bad     = job_nxt.cpu_bad || (in_data.period == '0) ||
                      ((in_data.func == rmsac_pkg::FUNC_ADMIT) && (in_data.budget == '0));
    // integer part of budget/period does not fit: quotient saturates
    job_nxt.sat     = (in_data.budget >> (rmsac_pkg::UTIL_W - FRAC_BITS)) >= in_data.period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (take) begin
      hold_valid_r <= 1'b1;
    end else if (!q_full) begin
      hold_valid_r <= 1'b0;
    end
    if (take) begin
      hold_r <= job_nxt;
    end
  end

endmodule

// ===== hdl/rmsac_queue.sv =====
// Short FIFO of classified requests between front and back.
// Depends on rmsac_pkg for the entry type and depth.

module rmsac_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rmsac_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output rmsac_pkg::job_t pop_data,
  output logic            empty
);

  localparam int DEPTH = rmsac_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rmsac_pkg::job_t  ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = cnt_r == (PTR_W + 1)'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/rmsac_div.sv =====
// Radix-2 restoring divider: floor(budget * 2^FRAC_BITS / period), 32 quotient bits.
// Caller guarantees the quotient fits; depends on rmsac_pkg for widths.

module rmsac_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] budget,
  input  logic [63:0] period,
  output logic        done,
  output logic [rmsac_pkg::UTIL_W-1:0] quo
);

  localparam int QW     = rmsac_pkg::UTIL_W;
  localparam int ITER_W = $clog2(QW + 1);

  logic              run_r;
  logic              done_r;
  logic [ITER_W-1:0] left_r;
  logic [63:0]       rem_r;
  logic [63:0]       per_r;
  logic [QW-1:0]     low_r;
  logic [QW-1:0]     quo_r;
  logic [64:0]       trial;
  logic [64:0]       diff;
  logic              ge;

  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = trial >= {1'b0, per_r};
  assign diff  = trial - {1'b0, per_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        left_r <= ITER_W'(QW);
      end else if (run_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == ITER_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= budget >> (QW - FRAC_BITS);
      low_r <= QW'(budget << FRAC_BITS);
      per_r <= period;
    end else if (run_r) begin
      rem_r <= ge ? diff[63:0] : trial[63:0];
      low_r <= low_r << 1;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

// ===== hdl/rmsac_back.sv =====
// Back end: per-CPU utilization/count tables, quotient, bound check and result register.
// Depends on rmsac_pkg and rmsac_div.

module rmsac_back #(
  parameter int NUM_CPUS  = 24,
  parameter int MAX_TASKS = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  rmsac_pkg::job_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output rmsac_pkg::out_t out_data
);

  localparam int UW     = rmsac_pkg::UTIL_W;
  localparam int TW     = rmsac_pkg::TASK_W;
  localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CALC, S_RESP} state_t;

  state_t          state_r, state_nxt;
  rmsac_pkg::job_t job_r, job_nxt;
  logic            need_div_r, need_div_nxt;
  logic [UW:0]     sum_r, sum_nxt;
  logic [UW-1:0]   sub_r, sub_nxt;
  logic [UW-1:0]   bound_r, bound_nxt;
  logic [UW-1:0]   util_cur_r, util_cur_nxt;
  logic [TW-1:0]   cnt_cur_r, cnt_cur_nxt;
  logic            out_valid_r, out_valid_nxt;
  rmsac_pkg::out_t out_r, out_nxt;

  logic [UW-1:0]       util_mem [NUM_CPUS];
  logic [TW-1:0]       cnt_mem  [NUM_CPUS];
  logic [NUM_CPUS-1:0] vld_r;
  logic [UW-1:0]       util_rd_r;
  logic [TW-1:0]       cnt_rd_r;
  logic                vld_rd_r;
  logic [CPU_AW-1:0]   rd_addr;
  logic [CPU_AW-1:0]   wr_addr;
  logic                wr_en;
  logic [UW-1:0]       wr_util;
  logic [TW-1:0]       wr_cnt;
  logic [UW-1:0]       util_rd;
  logic [TW-1:0]       cnt_rd;

  logic          div_start;
  logic          div_done;
  logic [UW-1:0] div_quo;
  logic [UW-1:0] quo;

  logic [UW-1:0] bound_tbl [rmsac_pkg::TASK_LIMIT];

  for (genvar g = 0; g < rmsac_pkg::TASK_LIMIT; g++) begin : g_bound
    localparam logic [UW-1:0] BND = rmsac_pkg::ll_bound(g + 1, FRAC_BITS);
    assign bound_tbl[g] = BND;
  end

  rmsac_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .budget (q_data.budget),
    .period (q_data.period),
    .done   (div_done),
    .quo    (div_quo)
  );

  assign rd_addr   = q_data.cpu[CPU_AW-1:0];
  assign wr_addr   = job_r.cpu[CPU_AW-1:0];
  assign util_rd   = vld_rd_r ? util_rd_r : '0;
  assign cnt_rd    = vld_rd_r ? cnt_rd_r : '0;
  assign quo       = job_r.sat ? '1 : div_quo;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      util_mem[wr_addr] <= wr_util;
      cnt_mem[wr_addr]  <= wr_cnt;
    end
    if (q_pop) begin
      util_rd_r <= util_mem[rd_addr];
      cnt_rd_r  <= cnt_mem[rd_addr];
      vld_rd_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    need_div_nxt  = need_div_r;
    sum_nxt       = sum_r;
    sub_nxt       = sub_r;
    bound_nxt     = bound_r;
    util_cur_nxt  = util_cur_r;
    cnt_cur_nxt   = cnt_cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    wr_en         = 1'b0;
    wr_util       = sum_r[UW-1:0];
    wr_cnt        = cnt_cur_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          job_nxt      = q_data;
          need_div_nxt = !q_data.bad && !q_data.sat;
          div_start    = !q_data.bad && !q_data.sat;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (!need_div_r || div_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        sum_nxt      = {1'b0, util_rd} + {1'b0, quo};
        sub_nxt      = (util_rd > quo) ? util_rd - quo : '0;
        bound_nxt    = bound_tbl[cnt_rd[rmsac_pkg::TASK_IDX_W-1:0]];
        util_cur_nxt = util_rd;
        cnt_cur_nxt  = cnt_rd;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.utilization = util_cur_r;
          out_nxt.task_count  = cnt_cur_r;
          if (job_r.cpu_bad) begin
            out_nxt.status      = rmsac_pkg::ST_BAD_PARM;
            out_nxt.utilization = '0;
            out_nxt.task_count  = '0;
          end else if (job_r.bad) begin
            out_nxt.status = rmsac_pkg::ST_BAD_PARM;
          end else if (job_r.func == rmsac_pkg::FUNC_ADMIT) begin
            if (cnt_cur_r >= TW'(MAX_TASKS)) begin
              out_nxt.status = rmsac_pkg::ST_FULL;
            end else if (sum_r <= {1'b0, bound_r}) begin
              out_nxt.status      = rmsac_pkg::ST_ADMITTED;
              out_nxt.utilization = sum_r[UW-1:0];
              out_nxt.task_count  = cnt_cur_r + 1'b1;
              wr_en               = 1'b1;
              wr_util             = sum_r[UW-1:0];
              wr_cnt              = cnt_cur_r + 1'b1;
            end else begin
              out_nxt.status = rmsac_pkg::ST_EXCEEDED;
            end
          end else begin
            out_nxt.status      = rmsac_pkg::ST_RELEASED;
            out_nxt.utilization = sub_r;
            out_nxt.task_count  = (cnt_cur_r != '0) ? cnt_cur_r - 1'b1 : '0;
            wr_en               = 1'b1;
            wr_util             = sub_r;
            wr_cnt              = (cnt_cur_r != '0) ? cnt_cur_r - 1'b1 : '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    need_div_r <= need_div_nxt;
    sum_r      <= sum_nxt;
    sub_r      <= sub_nxt;
    bound_r    <= bound_nxt;
    util_cur_r <= util_cur_nxt;
    cnt_cur_r  <= cnt_cur_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== hdl/rms_admission_control.sv =====
// Top level of the rate-monotonic admission controller.
// Depends on rmsac_pkg, rmsac_front, rmsac_queue and rmsac_back.
//
// Usage:
//   Requests arrive on in_valid/in_stall/in_data: func (admit or release), cpu, budget
//   and period. A transfer happens on a clock edge with in_valid high and in_stall low.
//   Each request yields exactly one result on out_valid/out_stall/out_data: status,
//   the CPU's utilization after the operation (unsigned Q8.24 by default) and its
//   task count.
//   The front stage registers and classifies a request, a two-entry queue decouples it
//   from the back end, which works on one request at a time.
//   An admission or release request with good parameters passes through the 32 steps
//   of the radix-2 quotient divider before out_valid rises. Requests with bad
//   parameters or a saturated quotient skip the divider. The back end takes the next
//   request only after the divider and table update for the last one are done.
//   The front keeps taking requests while the queue has room and a result waits.
//   While out_valid and out_stall are high the result register holds its contents; the back end
//   finishes its current request and then waits.
//   Synchronous reset (rst_n low) empties the queue and marks all CPU table entries as
//   zero utilization and zero tasks; no clearing pass is needed.

module rms_admission_control #(
  parameter int NUM_CPUS  = 24,
  parameter int MAX_TASKS = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rmsac_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rmsac_pkg::out_t out_data
);

  logic            push;
  rmsac_pkg::job_t push_data;
  logic            q_full;
  logic            q_pop;
  rmsac_pkg::job_t q_data;
  logic            q_empty;

  rmsac_front #(
    .NUM_CPUS  (NUM_CPUS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rmsac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  rmsac_back #(
    .NUM_CPUS  (NUM_CPUS),
    .MAX_TASKS (MAX_TASKS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/rmsac_checker.sv =====
// Port-level checks for rms_admission_control, attached with bind.
// Depends on rmsac_pkg.

module rmsac_port_checks #(
  parameter int MAX_TASKS = 64
) (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input rmsac_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= rmsac_pkg::ST_FULL &&
                  out_data.task_count <= rmsac_pkg::TASK_W'(MAX_TASKS))
    else $error("bad status code or task count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rmsac_pkg::ST_FULL |->
      out_data.task_count == rmsac_pkg::TASK_W'(MAX_TASKS))
    else $error("table full reported below the task limit");

  a_admit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rmsac_pkg::ST_ADMITTED |->
      out_data.task_count != '0)
    else $error("admitted task left the count at zero");

endmodule

bind rms_admission_control rmsac_port_checks #(.MAX_TASKS(MAX_TASKS)) u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
